>>> rtl/srsp_pkg.sv
// Shared types, constants and hue-step function for the serpentine rainbow pixel block.
`default_nettype none

package srsp_pkg;

   localparam int ROW_WIDTH       = 6;
   localparam int COLUMN_WIDTH    = 6;
   localparam int COUNT_WIDTH     = 7;
   localparam int STRIP_WIDTH     = 12;
   localparam int LEVEL_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int STEP_WIDTH      = 11;

   // Full hue circle: six phases of 255 each.
   localparam logic [STEP_WIDTH-1:0] HUE_SPAN = 11'd1530;

   localparam logic [COUNT_WIDTH-1:0] COLUMN_COUNT_RESET = 7'd8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_COUNT    = 8'd1;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] red;
      logic [LEVEL_WIDTH-1:0] green;
      logic [LEVEL_WIDTH-1:0] blue;
   } rgb_type;

   function automatic logic [LEVEL_WIDTH-1:0] clamp8(logic signed [12:0] v);
      logic [LEVEL_WIDTH-1:0] res;
      if (v < 13'sd0) begin
         res = 8'd0;
      end else if (v > 13'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // Apply the six hue phases in order, each seeing the result of the ones before.
   function automatic rgb_type hue_advance(rgb_type c, logic [STEP_WIDTH-1:0] step);
      logic signed [12:0] s;
      logic [LEVEL_WIDTH-1:0] r;
      logic [LEVEL_WIDTH-1:0] g;
      logic [LEVEL_WIDTH-1:0] b;
      rgb_type res;
      s = $signed({2'b00, step});
      r = c.red;
      g = c.green;
      b = c.blue;
      if (r == 8'd255 && g == 8'd0 && b < 8'd255) b = clamp8($signed({5'b0, b}) + s);
      if (r > 8'd0 && g == 8'd0 && b == 8'd255)   r = clamp8($signed({5'b0, r}) - s);
      if (r == 8'd0 && g < 8'd255 && b == 8'd255) g = clamp8($signed({5'b0, g}) + s);
      if (r == 8'd0 && g == 8'd255 && b > 8'd0)   b = clamp8($signed({5'b0, b}) - s);
      if (r < 8'd255 && g == 8'd255 && b == 8'd0) r = clamp8($signed({5'b0, r}) + s);
      if (r == 8'd255 && g > 8'd0 && b == 8'd0)   g = clamp8($signed({5'b0, g}) - s);
      res.red   = r;
      res.green = g;
      res.blue  = b;
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/srsp_ifs.sv
// Channel interfaces: pixel request, pixel response and register write.
`default_nettype none

interface srsp_req_if;
   import srsp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ROW_WIDTH-1:0]    pixel_row;
   logic [COLUMN_WIDTH-1:0] pixel_column;
   logic                    frame_done;
   modport source (output valid, output pixel_row, output pixel_column, output frame_done,
                   input ready);
   modport sink (input valid, input pixel_row, input pixel_column, input frame_done,
                 output ready);
endinterface

interface srsp_rsp_if;
   import srsp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STRIP_WIDTH-1:0] strip_index;
   logic [LEVEL_WIDTH-1:0] red_level;
   logic [LEVEL_WIDTH-1:0] green_level;
   logic [LEVEL_WIDTH-1:0] blue_level;
   modport source (output valid, output strip_index, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink (input valid, input strip_index, input red_level, input green_level,
                 input blue_level, output ready);
endinterface

interface srsp_csr_if;
   import srsp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [COUNT_WIDTH-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/srsp_hue_gen.sv
// Hue table builder: serial step divider followed by a one-entry-per-cycle fill sweep.
`default_nettype none

module srsp_hue_gen #(
   parameter int IW = 9,
   parameter int LW = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [LW-1:0]     table_len,
   output logic                   busy,
   output logic                   wr_en,
   output logic [IW-1:0]          wr_addr,
   output srsp_pkg::rgb_type      wr_data
);
   import srsp_pkg::*;

   typedef enum logic [3:0] {
      GEN_START  = 4'b0001,
      GEN_DIVIDE = 4'b0010,
      GEN_FILL   = 4'b0100,
      GEN_IDLE   = 4'b1000
   } gen_state_type;

   gen_state_type          state_ff, state_in;
   logic [LW-1:0]          rem_ff, rem_in;
   logic [3:0]             bit_ff, bit_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [IW-1:0]          fill_ff, fill_in;
   rgb_type                color_ff, color_in;
   logic [LW:0]            rem_sh;
   logic                   rem_ge;
   rgb_type                color_next;

   assign rem_sh     = {rem_ff, HUE_SPAN[bit_ff]};
   assign rem_ge     = rem_sh >= {1'b0, table_len};
   assign color_next = hue_advance(color_ff, step_ff);

   assign busy    = state_ff != GEN_IDLE;
   assign wr_en   = state_ff == GEN_FILL;
   assign wr_addr = fill_ff;
   assign wr_data = color_next;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      fill_in  = fill_ff;
      color_in = color_ff;
      case (state_ff)
         GEN_START: begin
            rem_in   = '0;
            bit_in   = 4'(STEP_WIDTH - 1);
            step_in  = '0;
            fill_in  = '0;
            color_in = '{red: 8'd255, green: 8'd0, blue: 8'd0};
            state_in = GEN_DIVIDE;
         end
         GEN_DIVIDE: begin
            // One quotient bit per cycle, most significant first.
            rem_in  = rem_ge ? LW'(rem_sh - {1'b0, table_len}) : rem_sh[LW-1:0];
            step_in = {step_ff[STEP_WIDTH-2:0], rem_ge};
            bit_in  = bit_ff - 4'd1;
            if (bit_ff == 4'd0) begin
               state_in = GEN_FILL;
            end
         end
         GEN_FILL: begin
            color_in = color_next;
            fill_in  = fill_ff + 1'b1;
            if (LW'(fill_ff) == table_len - 1'b1) begin
               state_in = GEN_IDLE;
            end
         end
         GEN_IDLE: begin
            state_in = GEN_IDLE;
         end
         default: begin
            state_in = GEN_START;
         end
      endcase
      if (start) begin
         state_in = GEN_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      step_ff  <= step_in;
      fill_ff  <= fill_in;
      color_ff <= color_in;
   end

endmodule

`default_nettype wire

>>> rtl/scrolling_rainbow_serpentine_pixels.sv
// Top level: serpentine LED matrix pixel colorer with a scrolling rainbow table.
`default_nettype none

// Returns each requested pixel's strip position and RGB color through input and output
// registers; requests and responses stream at one beat per clock, limited by the single
// read port of the hue table, while the response side is ready and no rebuild runs. After
// reset and each column count write the table is rebuilt, taking no request: the hue step
// is derived, then the table is filled one entry per cycle, 5 * columns entries (40 at
// the reset count of 8, at most 320). A column count write also resets the scroll offset.
// Columns beyond the row are clamped to the last column; odd rows run mirrored. A beat
// with frame_done set moves the rainbow by one entry for the following beats.
module scrolling_rainbow_serpentine_pixels #(
   parameter int MAX_COLUMNS  = 64,
   parameter int TABLE_FACTOR = 5
) (
   input  wire logic   clock,
   input  wire logic   reset,
   srsp_req_if.sink    req_ch,
   srsp_rsp_if.source  rsp_ch,
   srsp_csr_if.sink    csr_ch
);
   import srsp_pkg::*;

   localparam int TABLE_DEPTH = MAX_COLUMNS * TABLE_FACTOR;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_WIDTH-1:0]  column_count_ff;
   logic [COUNT_WIDTH-1:0]  col_eff;
   logic [LW-1:0]           table_len;
   logic                    csr_fire;
   logic                    gen_start;
   logic                    gen_busy;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   rgb_type                 wr_data;
   rgb_type                 hue_mem [TABLE_DEPTH];

   logic [IW-1:0]           offset_ff, offset_in;
   logic                    s1_valid_ff;
   logic [ROW_WIDTH-1:0]    s1_row_ff;
   logic [COLUMN_WIDTH-1:0] s1_col_ff;
   logic                    s1_done_ff;
   logic                    s2_valid_ff;
   logic [STRIP_WIDTH-1:0]  strip_ff;
   rgb_type                 rgb_ff;
   logic                    s2_adv;
   logic                    req_fire;
   logic [COUNT_WIDTH-1:0]  col_sat;
   logic [COUNT_WIDTH-1:0]  src_col;
   logic [LW:0]             idx_sum;
   logic [IW-1:0]           rd_addr;
   logic [LW-1:0]           offset_inc;
   logic [12:0]             strip_full;

   // Effective column count: zero acts as one, clamp to the table capacity.
   always_comb begin
      col_eff = column_count_ff;
      if (column_count_ff == '0) begin
         col_eff = 7'd1;
      end else if (int'(column_count_ff) > MAX_COLUMNS) begin
         col_eff = COUNT_WIDTH'(MAX_COLUMNS);
      end
   end

   assign table_len = LW'(int'(col_eff) * TABLE_FACTOR);

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign gen_start    = csr_fire && (csr_ch.index == REG_COLUMN_COUNT);

   // Row count has no bearing on any result; its writes are taken and dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (gen_start) begin
         column_count_ff <= csr_ch.data;
      end
   end

   srsp_hue_gen #(
      .IW          (IW),
      .LW          (LW)
   ) u_hue_gen (
      .clock     (clock),
      .reset     (reset),
      .start     (gen_start),
      .table_len (table_len),
      .busy      (gen_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // Pipeline handshake: input register, then table read into the output register.
   assign s2_adv       = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (!s1_valid_ff || s2_adv) && !gen_busy;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      col_sat = {1'b0, s1_col_ff};
      if ({1'b0, s1_col_ff} >= col_eff) begin
         col_sat = col_eff - 1'b1;
      end
      src_col = s1_row_ff[0] ? (col_eff - 1'b1 - col_sat) : col_sat;
      idx_sum = (LW + 1)'(offset_ff) + (LW + 1)'(src_col);
      if (idx_sum >= {1'b0, table_len}) begin
         idx_sum = idx_sum - {1'b0, table_len};
      end
      rd_addr    = idx_sum[IW-1:0];
      strip_full = 13'(col_eff) * 13'(s1_row_ff) + 13'(col_sat);
   end

   // Advance the scroll offset once the last pixel of a frame has read its color; a column count write clears it.
   always_comb begin
      offset_inc = LW'(offset_ff) + 1'b1;
      offset_in  = offset_ff;
      if (gen_start) begin
         offset_in = '0;
      end else if (s2_adv && s1_done_ff) begin
         offset_in = (offset_inc >= table_len) ? '0 : offset_inc[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_row_ff  <= req_ch.pixel_row;
         s1_col_ff  <= req_ch.pixel_column;
         s1_done_ff <= req_ch.frame_done;
      end
      if (s2_adv) begin
         strip_ff <= strip_full[STRIP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hue_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rgb_ff <= hue_mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = s2_valid_ff;
   assign rsp_ch.strip_index = strip_ff;
   assign rsp_ch.red_level   = rgb_ff.red;
   assign rsp_ch.green_level = rgb_ff.green;
   assign rsp_ch.blue_level  = rgb_ff.blue;

endmodule

`default_nettype wire
